// File: rtl/dwp_pkg.sv
`timescale 1ns / 1ps

package dwp_pkg;

	// Field widths of the stream and configuration channels.
	localparam int SPEED_W    = 16;
	localparam int GAIN_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_W      = 48;

	// Internal arithmetic widths.
	localparam int ERR_W  = SPEED_W + 1;
	localparam int SUM_W  = 32;
	localparam int PREV_W = 18;
	localparam int DIFF_W = PREV_W + 1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP_LEFT  = 3'd0,
		REG_KI_LEFT  = 3'd1,
		REG_KD_LEFT  = 3'd2,
		REG_KP_RIGHT = 3'd3,
		REG_KI_RIGHT = 3'd4,
		REG_KD_RIGHT = 3'd5
	} cfg_reg_e;

	// Reset values of the gains, signed Q8.8.
	localparam logic signed [GAIN_W-1:0] KP_RESET = 16'sd2048;
	localparam logic signed [GAIN_W-1:0] KI_RESET = 16'sd26;
	localparam logic signed [GAIN_W-1:0] KD_RESET = 16'sd0;

	// Gain set of one wheel.
	typedef struct packed {
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki;
		logic signed [GAIN_W-1:0] kd;
	} gains_t;

	localparam gains_t GAINS_RESET = '{kp: KP_RESET, ki: KI_RESET, kd: KD_RESET};

endpackage

// File: rtl/dwp_gains.sv
`timescale 1ns / 1ps

module dwp_gains (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [dwp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dwp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            wheel,
	output dwp_pkg::gains_t                 gains
);
	import dwp_pkg::*;

	gains_t left_q;
	gains_t right_q;

	// Gain register file; writes beyond the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= GAINS_RESET;
			right_q <= GAINS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_KP_LEFT:  left_q.kp  <= cfg_wdata;
				REG_KI_LEFT:  left_q.ki  <= cfg_wdata;
				REG_KD_LEFT:  left_q.kd  <= cfg_wdata;
				REG_KP_RIGHT: right_q.kp <= cfg_wdata;
				REG_KI_RIGHT: right_q.ki <= cfg_wdata;
				REG_KD_RIGHT: right_q.kd <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Hand out the gain set of the selected wheel.
	assign gains = wheel ? right_q : left_q;

endmodule

// File: rtl/dual_wheel_pid_step.sv
`timescale 1ns / 1ps

// Two-wheel PID speed step.
// Input channel s_*: one item per control step. tuser[0] selects a step (0)
// or a clear of both wheels' integrals and last errors (1); tuser[1] picks
// the wheel. tdata carries target speed (low half) and measured speed.
// Output channel m_*: one item per input item, in order, holding the
// saturated PID output in 1/256 units (zero for a clear item).
// Gains are written through cfg_wr_en/cfg_index/cfg_wdata while idle; the user ensures this.
// The block is a three-register pipeline: input stage, product stage and
// output register, which an item passes in that order. One item is taken
// every cycle while there is room. Per-wheel state is read and updated in
// the input stage, so items on the same wheel may follow back to back.
// When m_tready is low the output register holds its item; the stages
// behind it keep filling until all three are full, and only then does
// s_tready fall. Reset empties the pipeline, zeroes the integrals and last
// errors, and loads the default gains.
module dual_wheel_pid_step (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [31:0]                     s_tdata,   // [15:0] target_speed, [31:16] measured_speed
	input  logic [1:0]                      s_tuser,   // [0] func, [1] wheel
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [47:0]                     m_tdata,   // [47:0] drive_increment
	input  logic                            cfg_wr_en,
	input  logic [dwp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dwp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import dwp_pkg::*;

	localparam int P_KP_W = GAIN_W + ERR_W;
	localparam int P_KI_W = GAIN_W + SUM_W;
	localparam int P_KD_W = GAIN_W + DIFF_W;
	localparam int TOT_W  = OUT_W + 2;

	// Stage handshake.
	logic ready_out, ready_s2, ready_s1, adv_s1;

	// Input stage.
	logic               valid_s1;
	logic               func_s1;
	logic               wheel_s1;
	logic [SPEED_W-1:0] target_s1;
	logic [SPEED_W-1:0] measured_s1;

	// Product stage.
	logic                     valid_s2;
	logic                     clr_s2;
	logic signed [P_KP_W-1:0] p_kp_s2;
	logic signed [P_KI_W-1:0] p_ki_s2;
	logic signed [P_KD_W-1:0] p_kd_s2;

	// Output register.
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	// Per-wheel controller state.
	logic signed [SUM_W-1:0]  err_sum_q  [2];
	logic signed [PREV_W-1:0] prev_err_q [2];

	gains_t gains;

	logic signed [ERR_W-1:0]  err_d;
	logic signed [SUM_W-1:0]  sum_cur;
	logic signed [SUM_W:0]    sum_raw;
	logic signed [SUM_W-1:0]  sum_sat;
	logic signed [SUM_W-1:0]  sum_new;
	logic signed [PREV_W-1:0] prev_cur;
	logic signed [DIFF_W-1:0] diff_d;
	logic signed [P_KP_W-1:0] p_kp_d;
	logic signed [P_KI_W-1:0] p_ki_d;
	logic signed [P_KD_W-1:0] p_kd_d;
	logic signed [TOT_W-1:0]  total_d;
	logic [OUT_W-1:0]         out_sat_d;

	dwp_gains u_gains (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.wheel     (wheel_s1),
		.gains     (gains)
	);

	// Each stage moves on when the one after it is empty or moving.
	assign ready_out = !out_valid_q || m_tready;
	assign ready_s2  = !valid_s2 || ready_out;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign adv_s1    = valid_s1 && ready_s2;
	assign s_tready  = ready_s1;

	// Error, saturated integral and derivative difference.
	always_comb begin
		err_d    = $signed({1'b0, target_s1}) - $signed({1'b0, measured_s1});
		sum_cur  = err_sum_q[wheel_s1];
		prev_cur = prev_err_q[wheel_s1];
		sum_raw  = {sum_cur[SUM_W-1], sum_cur}
			+ {{(SUM_W + 1 - ERR_W){err_d[ERR_W-1]}}, err_d};
		if (sum_raw[SUM_W] != sum_raw[SUM_W-1]) begin
			sum_sat = sum_raw[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
				: {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_sat = sum_raw[SUM_W-1:0];
		end
		// Only a run of overspeed errors accumulates.
		sum_new = err_d[ERR_W-1] ? sum_sat : '0;
		diff_d  = {{(DIFF_W - ERR_W){err_d[ERR_W-1]}}, err_d}
			- {prev_cur[PREV_W-1], prev_cur};
	end

	// Three gain products, operands extended to the product width.
	assign p_kp_d = $signed({{(P_KP_W - GAIN_W){gains.kp[GAIN_W-1]}}, gains.kp})
		* $signed({{(P_KP_W - ERR_W){err_d[ERR_W-1]}}, err_d});
	assign p_ki_d = $signed({{(P_KI_W - GAIN_W){gains.ki[GAIN_W-1]}}, gains.ki})
		* $signed({{(P_KI_W - SUM_W){sum_new[SUM_W-1]}}, sum_new});
	assign p_kd_d = $signed({{(P_KD_W - GAIN_W){gains.kd[GAIN_W-1]}}, gains.kd})
		* $signed({{(P_KD_W - DIFF_W){diff_d[DIFF_W-1]}}, diff_d});

	// Sum of the terms, saturated to the output width.
	always_comb begin
		total_d = {{(TOT_W - P_KP_W){p_kp_s2[P_KP_W-1]}}, p_kp_s2}
			+ {{(TOT_W - P_KI_W){p_ki_s2[P_KI_W-1]}}, p_ki_s2}
			+ {{(TOT_W - P_KD_W){p_kd_s2[P_KD_W-1]}}, p_kd_s2};
		if ((total_d[TOT_W-1:OUT_W-1] != '0) && (total_d[TOT_W-1:OUT_W-1] != '1)) begin
			out_sat_d = total_d[TOT_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
				: {1'b0, {(OUT_W-1){1'b1}}};
		end else begin
			out_sat_d = total_d[OUT_W-1:0];
		end
	end

	// Input stage registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && ready_s1) begin
			func_s1     <= s_tuser[0];
			wheel_s1    <= s_tuser[1];
			target_s1   <= s_tdata[SPEED_W-1:0];
			measured_s1 <= s_tdata[2*SPEED_W-1:SPEED_W];
		end
	end

	// Per-wheel state is committed as the item leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_sum_q[0]  <= '0;
			err_sum_q[1]  <= '0;
			prev_err_q[0] <= '0;
			prev_err_q[1] <= '0;
		end else if (adv_s1) begin
			if (func_s1) begin
				err_sum_q[0]  <= '0;
				err_sum_q[1]  <= '0;
				prev_err_q[0] <= '0;
				prev_err_q[1] <= '0;
			end else begin
				err_sum_q[wheel_s1]  <= sum_new;
				prev_err_q[wheel_s1] <= {err_d[ERR_W-1], err_d};
			end
		end
	end

	// Product stage registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			clr_s2  <= func_s1;
			p_kp_s2 <= p_kp_d;
			p_ki_s2 <= p_ki_d;
			p_kd_s2 <= p_kd_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_out) begin
			out_data_q <= clr_s2 ? '0 : out_sat_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// A clear leaves both wheels with no integral and no last error.
	a_clear_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && func_s1 |=> (err_sum_q[0] == '0) && (err_sum_q[1] == '0)
			&& (prev_err_q[0] == '0) && (prev_err_q[1] == '0))
		else $error("state not cleared after a clear item");

	// Only overspeed errors accumulate, so an integral is never positive.
	a_sum_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		((!err_sum_q[0][SUM_W-1]) |-> (err_sum_q[0] == '0))
		and ((!err_sum_q[1][SUM_W-1]) |-> (err_sum_q[1] == '0)))
		else $error("integral became positive");

	// A step at or under target leaves that wheel's integral at zero.
	a_sum_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && !func_s1 && (target_s1 >= measured_s1)
			|=> err_sum_q[$past(wheel_s1)] == '0)
		else $error("integral not zeroed on an underspeed step");

	// A clear item reaches the output as zero.
	a_clear_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && clr_s2 && ready_out |=> m_tvalid && (m_tdata == '0))
		else $error("clear item gave a nonzero result");

	// The input side only stalls when the input stage, product stage and output register all hold an item.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && out_valid_q)
		else $error("input stalled with room in the pipeline");

endmodule

// File: tb/dual_wheel_pid_step_test.sv
`timescale 1ns / 1ps

module dual_wheel_pid_step_test;
	import dwp_pkg::*;

	localparam int HOLD_CYCLES     = 64;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 155;
	// Short run of maximal overspeed steps on one wheel with extreme gains.
	localparam int OVERSPEED_STEPS = 8;
	localparam int RUN_LIMIT_NS    = 2000000;

	localparam logic FUNC_STEP   = 1'b0;
	localparam logic FUNC_CLEAR  = 1'b1;
	localparam logic WHEEL_LEFT  = 1'b0;
	localparam logic WHEEL_RIGHT = 1'b1;

	// Register indexes past the last gain; writes to them must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;
	localparam logic [GAIN_W-1:0]  GAIN_MAX  = 16'h7FFF;
	localparam logic [GAIN_W-1:0]  GAIN_MIN  = 16'h8000;

	localparam longint SUM_HI = 64'sd2147483647;
	localparam longint SUM_LO = -64'sd2147483648;
	localparam longint OUT_HI = 64'sd140737488355327;
	localparam longint OUT_LO = -64'sd140737488355328;

	typedef struct packed {
		logic                func;
		logic [SPEED_W-1:0]  target;
		logic [SPEED_W-1:0]  measured;
		logic                wheel;
	} step_item_t;

	typedef struct packed {
		step_item_t          item;
		logic                typed;
		logic [OUT_W-1:0]    want;
	} directed_row_t;

	// Directed items with the reset gains; typed rows carry their result.
	localparam int DIRECTED_ROWS = 14;
	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{'{FUNC_STEP,  16'd0,     16'd0,     WHEEL_LEFT},  1'b1, 48'sd0},
		'{'{FUNC_STEP,  SPEED_MAX, 16'd0,     WHEEL_LEFT},  1'b1, 48'sd134215680},
		'{'{FUNC_STEP,  16'd0,     SPEED_MAX, WHEEL_RIGHT}, 1'b1, -48'sd135919590},
		'{'{FUNC_STEP,  16'd0,     SPEED_MAX, WHEEL_RIGHT}, 1'b0, 48'sd0},
		'{'{FUNC_STEP,  16'd1,     16'd0,     WHEEL_RIGHT}, 1'b0, 48'sd0},
		'{'{FUNC_STEP,  16'd0,     SPEED_MAX, WHEEL_RIGHT}, 1'b0, 48'sd0},
		'{'{FUNC_STEP,  SPEED_MAX, SPEED_MAX, WHEEL_LEFT},  1'b1, 48'sd0},
		'{'{FUNC_STEP,  16'd0,     16'd1,     WHEEL_LEFT},  1'b0, 48'sd0},
		'{'{FUNC_STEP,  16'd32768, 16'd32767, WHEEL_LEFT},  1'b0, 48'sd0},
		'{'{FUNC_CLEAR, SPEED_MAX, SPEED_MAX, WHEEL_RIGHT}, 1'b1, 48'sd0},
		'{'{FUNC_STEP,  16'd0,     SPEED_MAX, WHEEL_RIGHT}, 1'b1, -48'sd135919590},
		'{'{FUNC_STEP,  16'h5555,  16'hAAAA,  WHEEL_LEFT},  1'b0, 48'sd0},
		'{'{FUNC_STEP,  16'hAAAA,  16'h5555,  WHEEL_RIGHT}, 1'b0, 48'sd0},
		'{'{FUNC_CLEAR, 16'd0,     16'd0,     WHEEL_LEFT},  1'b1, 48'sd0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [31:0]           s_tdata = '0;   // [15:0] target_speed, [31:16] measured_speed
	logic [1:0]            s_tuser = '0;   // [0] func, [1] wheel
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [47:0]           m_tdata;        // [47:0] drive_increment
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Mirror of the controller state and gains.
	gains_t                wheel_gains [2] = '{GAINS_RESET, GAINS_RESET};
	logic signed [SUM_W-1:0]  integral [2] = '{32'sd0, 32'sd0};
	logic signed [PREV_W-1:0] last_err [2] = '{18'sd0, 18'sd0};

	logic [OUT_W-1:0]      drive_q [$];
	int                    mismatches = 0;
	int                    sender_idle_pct = 0;
	int                    recv_stall_pct = 0;
	int                    burst_req = 0;
	int                    burst_seen = 0;
	int                    hold_left = 0;

	dual_wheel_pid_step i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Computes the drive increment of one item and advances the mirrored state.
	function automatic logic [OUT_W-1:0] pid_drive(input step_item_t it);
		longint err;
		longint acc;
		longint diff;
		longint total;
		longint kp;
		longint ki;
		longint kd;
		if (it.func == FUNC_CLEAR) begin
			integral[0] = '0;
			integral[1] = '0;
			last_err[0] = '0;
			last_err[1] = '0;
			return '0;
		end
		kp = wheel_gains[it.wheel].kp;
		ki = wheel_gains[it.wheel].ki;
		kd = wheel_gains[it.wheel].kd;
		err = longint'(it.target) - longint'(it.measured);
		acc = longint'(integral[it.wheel]) + err;
		if (acc > SUM_HI) begin
			acc = SUM_HI;
		end else if (acc < SUM_LO) begin
			acc = SUM_LO;
		end
		// Only overspeed keeps its integral; any other step wipes it.
		if (it.target >= it.measured) begin
			acc = 0;
		end
		integral[it.wheel] = acc[SUM_W-1:0];
		diff = err - longint'(last_err[it.wheel]);
		total = kp * err + ki * acc + kd * diff;
		if (total > OUT_HI) begin
			total = OUT_HI;
		end else if (total < OUT_LO) begin
			total = OUT_LO;
		end
		last_err[it.wheel] = err[PREV_W-1:0];
		return total[OUT_W-1:0];
	endfunction

	// Speeds lean toward the ends of the range.
	function automatic logic [SPEED_W-1:0] pick_speed();
		case ($urandom_range(7))
			0: return '0;
			1: return SPEED_MAX;
			default: return SPEED_W'($urandom_range(65535));
		endcase
	endfunction

	// Mostly overspeed runs so the integrals build up, with some clears and noise.
	function automatic step_item_t random_step();
		step_item_t it;
		logic [SPEED_W-1:0] a;
		logic [SPEED_W-1:0] b;
		int roll;
		roll = $urandom_range(99);
		a = pick_speed();
		b = pick_speed();
		it.wheel = 1'($urandom_range(1));
		it.func = (roll < 4) ? FUNC_CLEAR : FUNC_STEP;
		if (roll < 64 && a > b) begin
			it.target = b;
			it.measured = a;
		end else if (roll < 64) begin
			it.target = a;
			it.measured = b;
		end else begin
			it.target = a;
			it.measured = pick_speed();
		end
		return it;
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain(input int phase, input logic [GAIN_W-1:0] dflt);
		case (phase)
			0: return dflt;
			1: return GAIN_MAX;
			2: return GAIN_MIN;
			default: return GAIN_W'($urandom_range(65535));
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_KP_LEFT:  wheel_gains[WHEEL_LEFT].kp = val;
			REG_KI_LEFT:  wheel_gains[WHEEL_LEFT].ki = val;
			REG_KD_LEFT:  wheel_gains[WHEEL_LEFT].kd = val;
			REG_KP_RIGHT: wheel_gains[WHEEL_RIGHT].kp = val;
			REG_KI_RIGHT: wheel_gains[WHEEL_RIGHT].ki = val;
			REG_KD_RIGHT: wheel_gains[WHEEL_RIGHT].kd = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic program_gains(input int phase);
		write_reg(REG_KP_LEFT,  pick_gain(phase, KP_RESET));
		write_reg(REG_KI_LEFT,  pick_gain(phase, KI_RESET));
		write_reg(REG_KD_LEFT,  pick_gain(phase, KD_RESET));
		write_reg(REG_KP_RIGHT, pick_gain(phase, KP_RESET));
		write_reg(REG_KI_RIGHT, pick_gain(phase, KI_RESET));
		write_reg(REG_KD_RIGHT, pick_gain(phase, KD_RESET));
	endtask

	task automatic set_pace(input int mode);
		case (mode)
			1: begin
				sender_idle_pct = 56;
				recv_stall_pct = 0;
			end
			2: begin
				sender_idle_pct = 0;
				recv_stall_pct = 56;
			end
			3: begin
				sender_idle_pct = 9;
				recv_stall_pct = 9;
			end
			default: begin
				sender_idle_pct = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	// Offers one item and records its result once the block takes it.
	task automatic send_step(input step_item_t it, input logic typed, input logic [OUT_W-1:0] want);
		logic [OUT_W-1:0] predicted;
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {it.measured, it.target};
		s_tuser <= {it.wheel, it.func};
		do begin
			@(posedge clk);
		end while (!s_tready);
		predicted = pid_drive(it);
		drive_q.push_back(typed ? want : predicted);
	endtask

	// Stops offering items and waits until every result has come back.
	task automatic close_phase();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (drive_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Result side: random stalls, plus long holds requested by the sender.
	always @(negedge clk) begin
		if (burst_seen != burst_req) begin
			burst_seen = burst_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Each result is matched against the oldest outstanding prediction.
	always @(posedge clk) begin
		logic [OUT_W-1:0] want;
		if (m_tvalid && m_tready) begin
			if (drive_q.size() == 0) begin
				$display("%0t: unexpected item, expected none, got drive_increment %0d",
					$time, $signed(m_tdata));
				mismatches++;
			end else begin
				want = drive_q.pop_front();
				if (m_tdata !== want) begin
					$display("%0t: drive_increment expected %0d, got %0d",
						$time, $signed(want), $signed(m_tdata));
					mismatches++;
				end
			end
		end
	end

	initial begin
		step_item_t it;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items on the reset gains.
		set_pace(0);
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			send_step(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
		end
		close_phase();

		// Random items over several gain settings and pacing modes.
		for (int p = 0; p < PHASES; p++) begin
			set_pace(p % 4);
			program_gains(p);
			if (p == 0) begin
				write_reg(REG_SPARE_LO, GAIN_MIN);
				write_reg(REG_SPARE_HI, GAIN_MAX);
			end
			if (p % 4 == 0) begin
				burst_req++;
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_step(random_step(), 1'b0, '0);
			end
			close_phase();
		end

		// Short overspeed run on the left wheel, then one step on each wheel.
		set_pace(0);
		program_gains(2);
		it = '{func: FUNC_CLEAR, target: '0, measured: '0, wheel: WHEEL_LEFT};
		send_step(it, 1'b0, '0);
		it = '{func: FUNC_STEP, target: '0, measured: SPEED_MAX, wheel: WHEEL_LEFT};
		for (int n = 0; n < OVERSPEED_STEPS; n++) begin
			send_step(it, 1'b0, '0);
		end
		it = '{func: FUNC_STEP, target: 16'd7, measured: 16'd3, wheel: WHEEL_RIGHT};
		send_step(it, 1'b0, '0);
		it = '{func: FUNC_STEP, target: 16'd5, measured: 16'd9, wheel: WHEEL_LEFT};
		send_step(it, 1'b0, '0);
		close_phase();

		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("dual_wheel_pid_step_test: clean");
		end else begin
			$display("dual_wheel_pid_step_test: errors");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(RUN_LIMIT_NS);
		$display("dual_wheel_pid_step_test: errors");
		$finish;
	end

endmodule
